/* src/mrpt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrpt_pkg: shared constants for the Miller-Rabin primality tester
// Witness table, trial limit, default data width.
// ----------------------------------------------------------------------------
package mrpt_pkg;
  localparam int DataWidthDef = 64;
  localparam int WitnessCount = 12;
  localparam int TrialLimit   = 38;
  localparam int WitW         = 6;

  function automatic logic [WitW-1:0] witness(input logic [3:0] idx);
    logic [WitW-1:0] w;
    begin
      case (idx)
        4'd0:    w = 6'd2;
        4'd1:    w = 6'd3;
        4'd2:    w = 6'd5;
        4'd3:    w = 6'd7;
        4'd4:    w = 6'd11;
        4'd5:    w = 6'd13;
        4'd6:    w = 6'd17;
        4'd7:    w = 6'd19;
        4'd8:    w = 6'd23;
        4'd9:    w = 6'd29;
        4'd10:   w = 6'd31;
        4'd11:   w = 6'd37;
        default: w = 6'd2;
      endcase
      return w;
    end
  endfunction

  typedef struct packed {
    logic go;
    logic done;
  } mm_ctl_t;
endpackage
`default_nettype wire

/* src/miller_rabin_prime_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// miller_rabin_prime_test: deterministic Miller-Rabin primality tester
// Trial division by 2..37, then strong probable-prime test on 12 witnesses.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with a candidate while busy is low; the word is taken on that
//   edge and busy rises. When the test ends, done is high for one cycle with
//   is_prime_flag valid; busy falls in the same cycle.
// Operation:
//   Trial division runs one divisor per step; each step reduces the candidate
//   mod p bit-serially. Each modular product goes through one bit-serial
//   multiplier. A witness takes about 2*DATA_WIDTH products for the
//   exponentiation plus up to r-1 squarings; composites usually leave
//   much earlier.
// Throughput: one candidate at a time.
// Reset clears the control state; any test in flight is dropped.
// The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test #(
  parameter int DATA_WIDTH = mrpt_pkg::DataWidthDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] candidate,
  output logic                       busy,
  output logic                       done,
  output logic                       is_prime_flag
);
  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam int PW = mrpt_pkg::WitW;

  typedef enum logic [3:0] {
    S_IDLE, S_TDIV, S_TCHK, S_SPLIT, S_WSTART, S_PMUL, S_PWAIT,
    S_PNEXT, S_WCHK, S_SQ, S_SQWAIT, S_FIN
  } state_t;

  state_t        state;
  logic [W-1:0]  n, nm1, d, e, base, res, x;
  logic [CW-1:0] r, j, cnt;
  logic [PW-1:0] p, rem;
  logic [W-1:0]  nsh;
  logic [3:0]    wi;
  logic          mul_res;     // which exponentiation product is running: 1 res*base, 0 base*base

  logic          mm_go, mm_done;
  logic [W-1:0]  mm_a, mm_b, mm_p;

  mrpt_mulmod #(.W(W)) u_mm (
    .clk(clk), .rst(rst), .go(mm_go), .a(mm_a), .b(mm_b), .m(n),
    .done(mm_done), .p(mm_p)
  );

  // serial remainder step: rem = (rem*2 + bit) mod p
  logic [PW:0] rem2;
  logic [PW-1:0] rem_next;
  always_comb begin
    rem2 = {rem, nsh[W-1]};
    rem_next = (rem2 >= {1'b0, p}) ? PW'(rem2 - {1'b0, p}) : PW'(rem2);
  end

  // p*p > n, p < 38 so p*p fits 11 bits
  logic [2*PW-1:0] psq;
  logic            psq_gt;
  assign psq    = p * p;
  assign psq_gt = (W > 2*PW) ? ((n >> (2*PW)) == '0 && W'(psq) > n) : (W'(psq) > n)
                  || ((2*PW > W) && (psq >> W) != '0);

  always_ff @(posedge clk) begin
    done  <= 1'b0;
    mm_go <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      is_prime_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            n    <= candidate;
            busy <= 1'b1;
            if (candidate < W'(2)) begin
              is_prime_flag <= 1'b0;
              state <= S_FIN;
            end else begin
              p   <= PW'(2);
              rem <= '0;
              nsh <= candidate;
              cnt <= CW'(W);
              state <= S_TCHK;
            end
          end
        end
        S_TCHK: begin
          if (p == PW'(mrpt_pkg::TrialLimit)) begin
            nm1   <= n - 1'b1;
            d     <= n - 1'b1;
            r     <= '0;
            state <= S_SPLIT;
          end else if (psq_gt) begin
            is_prime_flag <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          rem <= rem_next;
          nsh <= {nsh[W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            if (rem_next == '0) begin
              is_prime_flag <= (n == W'(p));
              state <= S_FIN;
            end else begin
              p   <= p + 1'b1;
              rem <= '0;
              nsh <= n;
              cnt <= CW'(W);
              state <= S_TCHK;
            end
          end
        end
        S_SPLIT: begin
          if (!d[0] && d != '0) begin
            d <= d >> 1;
            r <= r + 1'b1;
          end else begin
            wi <= '0;
            state <= S_WSTART;
          end
        end
        S_WSTART: begin
          if (wi == 4'(mrpt_pkg::WitnessCount)) begin
            is_prime_flag <= 1'b1;
            state <= S_FIN;
          end else begin
            // n > 37 here, so witness < n
            base <= W'(mrpt_pkg::witness(wi));
            res  <= W'(1);
            e    <= d;
            state <= S_PNEXT;
          end
        end
        S_PNEXT: begin
          if (e == '0) begin
            x <= res;
            state <= S_WCHK;
          end else if (e[0]) begin
            mul_res <= 1'b1;
            mm_go   <= 1'b1;
            state   <= S_PWAIT;
          end else begin
            mul_res <= 1'b0;
            mm_go   <= 1'b1;
            state   <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (mm_done) begin
            if (mul_res) begin
              res     <= mm_p;
              mul_res <= 1'b0;
              mm_go   <= 1'b1;
            end else begin
              base  <= mm_p;
              e     <= e >> 1;
              state <= S_PNEXT;
            end
          end
        end
        S_WCHK: begin
          if (x == W'(1) || x == nm1) begin
            wi <= wi + 1'b1;
            state <= S_WSTART;
          end else begin
            j <= CW'(1);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (j >= r) begin
            is_prime_flag <= 1'b0;
            state <= S_FIN;
          end else begin
            mm_go <= 1'b1;
            state <= S_SQWAIT;
          end
        end
        S_SQWAIT: begin
          if (mm_done) begin
            x <= mm_p;
            if (mm_p == nm1) begin
              wi <= wi + 1'b1;
              state <= S_WSTART;
            end else begin
              j <= j + 1'b1;
              state <= S_SQ;
            end
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // multiplier operands
  always_comb begin
    if (state == S_SQ || state == S_SQWAIT) begin
      mm_a = x;
      mm_b = x;
    end else if (mul_res) begin
      mm_a = res;
      mm_b = base;
    end else begin
      mm_a = base;
      mm_b = base;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than a cycle");
`endif
endmodule
`default_nettype wire

/* src/mrpt_mulmod.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrpt_mulmod: bit-serial modular multiplier
// acc = a*b mod m, one multiplier bit (msb first) per cycle.
// ----------------------------------------------------------------------------
module mrpt_mulmod #(
  parameter int W = mrpt_pkg::DataWidthDef
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      p
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc, bsh, a_r, m_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    dbl, dbl_r, sum;
  logic [W-1:0]  acc2, acc3;

  always_comb begin
    dbl  = {acc, 1'b0};
    acc2 = (dbl >= {1'b0, m_r}) ? W'(dbl - {1'b0, m_r}) : W'(dbl);
    sum  = {1'b0, acc2} + {1'b0, a_r};
    dbl_r = sum;
    acc3 = bsh[W-1] ? ((dbl_r >= {1'b0, m_r}) ? W'(dbl_r - {1'b0, m_r}) : W'(dbl_r))
                    : acc2;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      acc  <= '0;
      bsh  <= b;
      a_r  <= a;
      m_r  <= m;
      cnt  <= CW'(W);
    end else if (busy) begin
      acc <= acc3;
      bsh <= {bsh[W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // final product sits in acc while done is high
  assign p = acc;
endmodule
`default_nettype wire
